### hdl/ffa_pkg.sv
// Shared constants of the first-fit heap allocator: stream layout, request and status codes.
package ffa_pkg;

  localparam int IN_TDATA_W  = 32;
  localparam int IN_TUSER_W  = 1;
  localparam int OUT_TDATA_W = 40;

  localparam int BYTES_W  = 16;
  localparam int OFFSET_W = 16;
  localparam int STATUS_W = 2;
  localparam int USED_W   = 17;
  localparam int NEED_W   = 17;

  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_OOM = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BAD = 2'd2;

  localparam int MIN_PAYLOAD = 8;
  localparam logic [NEED_W-1:0] ALIGN_MASK = ~17'd7;

endpackage

### hdl/ffa_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
module ffa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

### hdl/first_fit_heap_allocator_core.sv
// First-fit heap allocator with forward coalescing. Block headers (in-use mark, free
// mark, payload size) live in one RAM with one entry per heap byte address and a
// registered read. After reset the core sweeps the RAM (in_tready low) and seeds one
// free block covering the heap. Every step of the chain walk waits on the RAM read: an
// allocate visits headers in address order and takes one more step when a split writes
// the remainder header; a free reads the block's header and then the following headers
// (the merged blocks plus the one that stops the merge, if any), stops after the first
// read when the block is not in use, and reads nothing when the offset is null, below
// the header size or past the heap. One item is in work at a time; a finished result
// waits in the output register while the next item is accepted, and the core stalls
// only when a second result is ready before the first has left.
module first_fit_heap_allocator_core #(
  parameter int HEAP_BYTES   = 65536,
  parameter int HEADER_BYTES = 12
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [ffa_pkg::IN_TDATA_W-1:0] in_tdata,   // request_bytes, free_offset
  input  logic [ffa_pkg::IN_TUSER_W-1:0] in_tuser,   // req_type
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [ffa_pkg::OUT_TDATA_W-1:0] out_tdata  // payload_offset, status, used_bytes, pad
);
  import ffa_pkg::*;

  localparam int AW = $clog2(HEAP_BYTES);
  localparam int SW = AW;
  localparam int EW = SW + 2;
  localparam int NW = AW + 2;

  localparam logic [3:0] S_CLR  = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_AISS = 4'd2;
  localparam logic [3:0] S_ACHK = 4'd3;
  localparam logic [3:0] S_AMRK = 4'd4;
  localparam logic [3:0] S_FISS = 4'd5;
  localparam logic [3:0] S_FCHK = 4'd6;
  localparam logic [3:0] S_CISS = 4'd7;
  localparam logic [3:0] S_CCHK = 4'd8;
  localparam logic [3:0] S_FWB  = 4'd9;
  localparam logic [3:0] S_DONE = 4'd10;

  function automatic logic [USED_W-1:0] to_used(input logic [SW-1:0] sz);
    logic [SW+USED_W-1:0] wide;
    wide = {{USED_W{1'b0}}, sz};
    return wide[USED_W-1:0];
  endfunction

  logic [3:0]             state_r, state_nxt;
  logic [AW-1:0]          clr_cnt_r, clr_cnt_nxt;
  logic [AW-1:0]          cur_r, cur_nxt;
  logic [AW-1:0]          base_r, base_nxt;
  logic [SW-1:0]          bsize_r, bsize_nxt;
  logic [NEED_W-1:0]      need_r, need_nxt;
  logic [USED_W-1:0]      used_r, used_nxt;
  logic [OFFSET_W-1:0]    res_off_r, res_off_nxt;
  logic [STATUS_W-1:0]    res_st_r, res_st_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [OUT_TDATA_W-1:0] out_data_r, out_data_nxt;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [EW-1:0] ram_wdata;
  logic [EW-1:0] ram_rdata;

  logic          rd_live, rd_free;
  logic [SW-1:0] rd_size;
  logic [NW-1:0] n_sum, m_size, m_next;
  logic          fit, split;
  logic [BYTES_W-1:0]  req_bytes;
  logic [OFFSET_W-1:0] free_off, free_s;
  logic [NEED_W-1:0]   need_raw;
  logic                free_bad;

  ffa_ram #(.WIDTH(EW), .DEPTH(HEAP_BYTES)) u_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_addr (cur_r),
    .rd_data (ram_rdata)
  );

  assign rd_live = ram_rdata[EW-1];
  assign rd_free = ram_rdata[EW-2];
  assign rd_size = ram_rdata[SW-1:0];

  assign n_sum  = NW'(cur_r) + NW'(HEADER_BYTES) + NW'(rd_size);
  assign m_size = NW'(bsize_r) + NW'(HEADER_BYTES) + NW'(rd_size);
  assign m_next = NW'(base_r) + NW'(HEADER_BYTES) + m_size;
  assign fit    = rd_free && (32'(rd_size) >= 32'(need_r));
  assign split  = (32'(rd_size) - 32'(need_r)) > 32'(HEADER_BYTES + MIN_PAYLOAD);

  assign req_bytes = in_tdata[BYTES_W-1:0];
  assign free_off  = in_tdata[BYTES_W+OFFSET_W-1:BYTES_W];
  assign free_s    = free_off - OFFSET_W'(HEADER_BYTES);
  assign need_raw  = (req_bytes == '0) ? NEED_W'(MIN_PAYLOAD) : NEED_W'(req_bytes);
  assign free_bad  = (free_off < OFFSET_W'(HEADER_BYTES)) ||
                     (32'(free_s) >= 32'(HEAP_BYTES));

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_comb begin
    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    cur_nxt       = cur_r;
    base_nxt      = base_r;
    bsize_nxt     = bsize_r;
    need_nxt      = need_r;
    used_nxt      = used_r;
    res_off_nxt   = res_off_r;
    res_st_nxt    = res_st_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    ram_we        = 1'b0;
    ram_waddr     = cur_r;
    ram_wdata     = '0;

    case (state_r)
      S_CLR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_cnt_r;
        if (clr_cnt_r == '0) begin
          ram_wdata = {1'b1, 1'b1, SW'(HEAP_BYTES - HEADER_BYTES)};
        end
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == AW'(HEAP_BYTES - 1)) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        if (in_tvalid) begin
          res_off_nxt = '0;
          if (in_tuser[0] == REQ_ALLOC) begin
            need_nxt  = (need_raw + NEED_W'(7)) & ALIGN_MASK;
            cur_nxt   = '0;
            state_nxt = S_AISS;
          end else if (free_bad) begin
            res_st_nxt = ST_BAD;
            state_nxt  = S_DONE;
          end else begin
            cur_nxt   = AW'(free_s);
            base_nxt  = AW'(free_s);
            state_nxt = S_FISS;
          end
        end
      end

      S_AISS: state_nxt = S_ACHK;

      S_ACHK: begin
        if (!rd_live) begin
          res_st_nxt = ST_OOM;
          state_nxt  = S_DONE;
        end else if (fit) begin
          res_st_nxt  = ST_OK;
          res_off_nxt = OFFSET_W'(NW'(cur_r) + NW'(HEADER_BYTES));
          if (split) begin
            // remainder header first, then shrink and mark this block
            ram_we    = 1'b1;
            ram_waddr = AW'(NW'(cur_r) + NW'(HEADER_BYTES) + NW'(need_r));
            ram_wdata = {1'b1, 1'b1,
                         SW'(32'(rd_size) - 32'(need_r) - 32'(HEADER_BYTES))};
            bsize_nxt = SW'(need_r);
            state_nxt = S_AMRK;
          end else begin
            ram_we    = 1'b1;
            ram_wdata = {1'b1, 1'b0, rd_size};
            used_nxt  = used_r + to_used(rd_size);
            state_nxt = S_DONE;
          end
        end else if (n_sum >= NW'(HEAP_BYTES)) begin
          res_st_nxt = ST_OOM;
          state_nxt  = S_DONE;
        end else begin
          cur_nxt   = AW'(n_sum);
          state_nxt = S_AISS;
        end
      end

      S_AMRK: begin
        ram_we    = 1'b1;
        ram_wdata = {1'b1, 1'b0, bsize_r};
        used_nxt  = used_r + to_used(bsize_r);
        state_nxt = S_DONE;
      end

      S_FISS: state_nxt = S_FCHK;

      S_FCHK: begin
        if (!rd_live || rd_free) begin
          res_st_nxt = ST_BAD;
          state_nxt  = S_DONE;
        end else begin
          used_nxt  = used_r - to_used(rd_size);
          bsize_nxt = rd_size;
          if (n_sum >= NW'(HEAP_BYTES)) begin
            state_nxt = S_FWB;
          end else begin
            cur_nxt   = AW'(n_sum);
            state_nxt = S_CISS;
          end
        end
      end

      S_CISS: state_nxt = S_CCHK;

      S_CCHK: begin
        if (rd_live && rd_free) begin
          // absorb the neighbor and wipe its header
          ram_we    = 1'b1;
          ram_wdata = '0;
          bsize_nxt = SW'(m_size);
          if (m_next >= NW'(HEAP_BYTES)) begin
            state_nxt = S_FWB;
          end else begin
            cur_nxt   = AW'(m_next);
            state_nxt = S_CISS;
          end
        end else begin
          state_nxt = S_FWB;
        end
      end

      S_FWB: begin
        ram_we     = 1'b1;
        ram_waddr  = base_r;
        ram_wdata  = {1'b1, 1'b1, bsize_r};
        res_st_nxt = ST_OK;
        state_nxt  = S_DONE;
      end

      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {{(OUT_TDATA_W - OFFSET_W - STATUS_W - USED_W){1'b0}},
                           used_r, res_st_r, res_off_r};
          state_nxt     = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_cnt_r   <= '0;
      used_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      used_r      <= used_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r      <= cur_nxt;
    base_r     <= base_nxt;
    bsize_r    <= bsize_nxt;
    need_r     <= need_nxt;
    res_off_r  <= res_off_nxt;
    res_st_r   <= res_st_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

### hdl/ffa_chk.sv
// Port-level checks for the first-fit heap allocator, bound to the top level.
module ffa_chk (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [ffa_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import ffa_pkg::*;

  logic [OFFSET_W-1:0] res_off;
  logic [STATUS_W-1:0] res_st;

  assign res_off = out_tdata[OFFSET_W-1:0];
  assign res_st  = out_tdata[OFFSET_W+STATUS_W-1:OFFSET_W];

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result item changed while stalled");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (res_st == ST_OK || res_st == ST_OOM || res_st == ST_BAD))
    else $error("undefined status code");

  a_oom_null: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && res_st == ST_OOM |-> res_off == '0)
    else $error("failed allocate returned nonzero offset");

  a_bad_null: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && res_st == ST_BAD |-> res_off == '0)
    else $error("ignored free returned nonzero offset");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second item accepted while one is in work");

endmodule

bind first_fit_heap_allocator_core ffa_chk u_ffa_chk (.*);
